[rtl/qrs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and fixed widths shared by the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int COEF_W = 32;   // coefficient width
  localparam int DMAG_W = 66;   // |b*b - 4*a*c| magnitude width
  localparam int DEN_W  = 33;   // 2*|a|
  localparam int RES_W  = 64;   // result width

  localparam logic [RES_W-1:0] RES_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [RES_W-1:0] RES_NEG_MAG = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    RC_TWO_REAL = 2'd0,
    RC_DOUBLE   = 2'd1,
    RC_COMPLEX  = 2'd2,
    RC_A_ZERO   = 2'd3
  } root_case_t;

  // sideband riding along the square root pipeline
  typedef struct packed {
    root_case_t               rc;
    logic                     sa;    // a > 0
    logic signed [DEN_W-1:0]  p;     // a > 0 ? -b : b
    logic        [DEN_W-1:0]  den;   // 2*|a|
  } sqrt_sb_t;

  // sideband riding along the first divider
  typedef struct packed {
    root_case_t rc;
    logic       zneg;
  } div_sb_t;

  typedef struct packed {
    root_case_t              rc;
    logic signed [RES_W-1:0] first;
    logic signed [RES_W-1:0] second;
    logic signed [RES_W-1:0] imag;
    logic                    sat;
  } result_t;

endpackage

[rtl/qrs_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt #(
  parameter int RW   = 66,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_v,
  output logic [RW-1:0]     out_root,
  output logic              out_exact,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 1;
  localparam int CW   = REMW + 3;

  logic [RW-1:0]   v_r;
  logic [REMW-1:0] rem_r    [RW];
  logic [RW-1:0]   root_r   [RW];
  logic [RADW-1:0] rad_r    [RW];
  logic [SB_W-1:0] sb_r     [RW];
  logic [REMW-1:0] rem_nxt  [RW];
  logic [RW-1:0]   root_nxt [RW];
  logic [RADW-1:0] rad_nxt  [RW];

  genvar k;
  for (k = 0; k < RW; k++) begin : g_stage
    logic [REMW-1:0] rem_p;
    logic [RW-1:0]   root_p;
    logic [RADW-1:0] rad_p;
    logic [CW-1:0]   cur;
    logic [CW-1:0]   trial;
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = in_rad;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign rad_p  = rad_r[k-1];
    end
    assign cur         = {1'b0, rem_p, rad_p[RADW-1 -: 2]};
    assign trial       = cur - CW'({root_p, 2'b01});
    assign rem_nxt[k]  = trial[CW-1] ? cur[REMW-1:0] : trial[REMW-1:0];
    assign root_nxt[k] = {root_p[RW-2:0], ~trial[CW-1]};
    assign rad_nxt[k]  = rad_p << 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[RW-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= in_sb;
      for (int i = 0; i < RW; i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rad_r[i]  <= rad_nxt[i];
      end
      for (int i = 1; i < RW; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign out_v     = v_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_exact = (rem_r[RW-1] == '0);
  assign out_sb    = sb_r[RW-1];

endmodule

[rtl/qrs_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div #(
  parameter int QW   = 67,
  parameter int DW   = 33,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_v,
  input  logic [QW-1:0]   in_num,
  input  logic [DW-1:0]   in_den,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_v,
  output logic [QW-1:0]   out_quo,
  output logic            out_rem_nz,
  output logic [SB_W-1:0] out_sb
);

  logic [QW-1:0]   v_r;
  logic [DW-1:0]   rem_r   [QW];
  logic [QW-1:0]   quo_r   [QW];
  logic [QW-1:0]   num_r   [QW];
  logic [DW-1:0]   den_r   [QW];
  logic [SB_W-1:0] sb_r    [QW];
  logic [DW-1:0]   rem_nxt [QW];
  logic [QW-1:0]   quo_nxt [QW];
  logic [QW-1:0]   num_nxt [QW];

  genvar k;
  for (k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_p;
    logic [QW-1:0] quo_p;
    logic [QW-1:0] num_p;
    logic [DW-1:0] den_p;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;
    if (k == 0) begin : g_first
      assign rem_p = '0;
      assign quo_p = '0;
      assign num_p = in_num;
      assign den_p = in_den;
    end else begin : g_next
      assign rem_p = rem_r[k-1];
      assign quo_p = quo_r[k-1];
      assign num_p = num_r[k-1];
      assign den_p = den_r[k-1];
    end
    assign cur        = {rem_p, num_p[QW-1]};
    assign diff       = cur - {1'b0, den_p};
    assign ge         = (cur >= {1'b0, den_p});
    assign rem_nxt[k] = ge ? diff[DW-1:0] : cur[DW-1:0];
    assign quo_nxt[k] = {quo_p[QW-2:0], ge};
    assign num_nxt[k] = num_p << 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0]  <= in_sb;
      den_r[0] <= in_den;
      for (int i = 0; i < QW; i++) begin
        rem_r[i] <= rem_nxt[i];
        quo_r[i] <= quo_nxt[i];
        num_r[i] <= num_nxt[i];
      end
      for (int i = 1; i < QW; i++) begin
        sb_r[i]  <= sb_r[i-1];
        den_r[i] <= den_r[i-1];
      end
    end
  end

  assign out_v      = v_r[QW-1];
  assign out_quo    = quo_r[QW-1];
  assign out_rem_nz = |rem_r[QW-1];
  assign out_sb     = sb_r[QW-1];

endmodule

[rtl/quadratic_root_solver.sv]
`timescale 1ns / 1ps
// Pipeline: stage 1, stage 2, the square root pipeline (OUT_FRAC_BITS+34 stages),
//   stage 3, stage 4, the two dividers (OUT_FRAC_BITS+35 stages) running in lockstep
//   and the output register. Throughput: one beat per cycle while the skid entry is empty.
// An output register plus one skid entry decouples in_ready from out_ready.
// Reset clears valid bits and the output handshake; data registers are not reset.
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c from signed fixed point coefficients, exact
// discriminant, rounded and saturated fixed point results.
// ----------------------------------------------------------------------------
module quadratic_root_solver #(
  parameter int OUT_FRAC_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [31:0]      in_coef_a,
  input  logic signed [31:0]      in_coef_b,
  input  logic signed [31:0]      in_coef_c,
  output logic                    out_valid,
  input  logic                    out_ready,
  output qrs_pkg::root_case_t     out_root_case,
  output logic signed [63:0]      out_first_real,
  output logic signed [63:0]      out_second_real,
  output logic signed [63:0]      out_imag_part,
  output logic                    out_saturated
);

  import qrs_pkg::*;

  localparam int RW   = DMAG_W / 2 + OUT_FRAC_BITS + 1;
  localparam int RADW = 2 * RW;
  localparam int QW   = RW + 1;
  localparam int ZW   = QW + 1;
  localparam int MW   = (QW > RES_W) ? QW : RES_W;
  localparam int DSCW = DMAG_W + 1;

  logic en;
  logic skid_v_r;
  assign en       = ~skid_v_r;
  assign in_ready = en;

  // ---- stage 1: products, divisor, sign of a
  logic                    s1_v_r;
  logic signed [63:0]      s1_bb_r;
  logic signed [63:0]      s1_ac_r;
  logic                    s1_az_r;
  sqrt_sb_t                s1_sb_r;
  logic signed [DEN_W-1:0] a_ext;
  logic signed [DEN_W-1:0] b_ext;
  logic        [DEN_W-1:0] a_mag;
  logic                    a_pos;
  sqrt_sb_t                s1_sb_nxt;

  always_comb begin
    a_ext         = {in_coef_a[31], in_coef_a};
    b_ext         = {in_coef_b[31], in_coef_b};
    a_mag         = in_coef_a[31] ? -a_ext : a_ext;
    a_pos         = ~in_coef_a[31] && (in_coef_a != '0);
    s1_sb_nxt.rc  = RC_TWO_REAL;
    s1_sb_nxt.sa  = a_pos;
    s1_sb_nxt.p   = a_pos ? -b_ext : b_ext;
    s1_sb_nxt.den = {a_mag[DEN_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_bb_r <= in_coef_b * in_coef_b;
      s1_ac_r <= in_coef_a * in_coef_c;
      s1_az_r <= (in_coef_a == '0);
      s1_sb_r <= s1_sb_nxt;
    end
  end

  // ---- stage 2: discriminant and case
  logic                     s2_v_r;
  logic [DMAG_W-1:0]        s2_dmag_r;
  sqrt_sb_t                 s2_sb_r;
  logic signed [DSCW-1:0]   dsc;
  logic signed [DSCW-1:0]   dsc_abs;
  sqrt_sb_t                 s2_sb_nxt;

  always_comb begin
    dsc       = {3'b000, s1_bb_r} - {s1_ac_r[63], s1_ac_r, 2'b00};
    dsc_abs   = dsc[DSCW-1] ? -dsc : dsc;
    s2_sb_nxt = s1_sb_r;
    if (s1_az_r) begin
      s2_sb_nxt.rc = RC_A_ZERO;
    end else if (dsc == '0) begin
      s2_sb_nxt.rc = RC_DOUBLE;
    end else if (dsc[DSCW-1]) begin
      s2_sb_nxt.rc = RC_COMPLEX;
    end else begin
      s2_sb_nxt.rc = RC_TWO_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_dmag_r <= dsc_abs[DMAG_W-1:0];
      s2_sb_r   <= s2_sb_nxt;
    end
  end

  // ---- square root of |D| * 2^(2F+2)
  logic          sq_v;
  logic [RW-1:0] sq_root;
  logic          sq_exact;
  sqrt_sb_t      sq_sb;

  qrs_sqrt #(
    .RW   (RW),
    .SB_W ($bits(sqrt_sb_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_v      (s2_v_r),
    .in_rad    (RADW'(s2_dmag_r) << (2 * OUT_FRAC_BITS + 2)),
    .in_sb     (s2_sb_r),
    .out_v     (sq_v),
    .out_root  (sq_root),
    .out_exact (sq_exact),
    .out_sb    (sq_sb)
  );

  // ---- stage 3: numerators
  logic                 s3_v_r;
  logic signed [ZW-1:0] s3_z1_r;
  logic signed [ZW-1:0] s3_z2_r;
  sqrt_sb_t             s3_sb_r;
  logic signed [ZW-1:0] p_sh;
  logic signed [ZW-1:0] r_lo;
  logic signed [ZW-1:0] r_hi;
  logic signed [ZW-1:0] z1_nxt;
  logic signed [ZW-1:0] z2_nxt;

  always_comb begin
    p_sh   = ZW'(sq_sb.p) <<< (OUT_FRAC_BITS + 1);
    r_lo   = ZW'(sq_root);
    r_hi   = r_lo + {{(ZW-1){1'b0}}, ~sq_exact};   // ceiling root for the subtracted term
    z1_nxt = p_sh;
    z2_nxt = p_sh;
    case (sq_sb.rc)
      RC_TWO_REAL: begin
        z1_nxt = sq_sb.sa ? p_sh + r_lo : p_sh - r_hi;
        z2_nxt = sq_sb.sa ? p_sh - r_hi : p_sh + r_lo;
      end
      RC_COMPLEX: begin
        z2_nxt = sq_sb.sa ? r_lo : -r_hi;
      end
      default: begin
        z2_nxt = p_sh;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_z1_r <= z1_nxt;
      s3_z2_r <= z2_nxt;
      s3_sb_r <= sq_sb;
    end
  end

  // ---- stage 4: sign and magnitude
  logic             s4_v_r;
  logic [QW-1:0]    s4_m1_r;
  logic [QW-1:0]    s4_m2_r;
  logic [DEN_W-1:0] s4_den_r;
  div_sb_t          s4_sb1_r;
  logic             s4_zneg2_r;
  logic [ZW-1:0]    z1_abs;
  logic [ZW-1:0]    z2_abs;

  assign z1_abs = s3_z1_r[ZW-1] ? -s3_z1_r : s3_z1_r;
  assign z2_abs = s3_z2_r[ZW-1] ? -s3_z2_r : s3_z2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_m1_r       <= z1_abs[QW-1:0];
      s4_m2_r       <= z2_abs[QW-1:0];
      s4_den_r      <= s3_sb_r.den;
      s4_sb1_r.rc   <= s3_sb_r.rc;
      s4_sb1_r.zneg <= s3_z1_r[ZW-1];
      s4_zneg2_r    <= s3_z2_r[ZW-1];
    end
  end

  // ---- dividers
  logic          dv_v;
  logic          dv2_v;
  logic [QW-1:0] quo  [2];
  logic          rnz  [2];
  logic          zneg [2];
  div_sb_t       d1_sb;

  qrs_div #(
    .QW   (QW),
    .DW   (DEN_W),
    .SB_W ($bits(div_sb_t))
  ) u_div1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (s4_v_r),
    .in_num     (s4_m1_r),
    .in_den     (s4_den_r),
    .in_sb      (s4_sb1_r),
    .out_v      (dv_v),
    .out_quo    (quo[0]),
    .out_rem_nz (rnz[0]),
    .out_sb     (d1_sb)
  );

  qrs_div #(
    .QW   (QW),
    .DW   (DEN_W),
    .SB_W (1)
  ) u_div2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (s4_v_r),
    .in_num     (s4_m2_r),
    .in_den     (s4_den_r),
    .in_sb      (s4_zneg2_r),
    .out_v      (dv2_v),
    .out_quo    (quo[1]),
    .out_rem_nz (rnz[1]),
    .out_sb     (zneg[1])
  );

  assign zneg[0] = d1_sb.zneg;

  // ---- round half up, saturate, select by case
  logic signed [RES_W-1:0] val [2];
  logic                    sat [2];
  result_t                 res_nxt;

  always_comb begin
    logic [QW:0]   qq;
    logic [MW-1:0] m;
    for (int i = 0; i < 2; i++) begin
      qq = {1'b0, quo[i]} + (QW+1)'(zneg[i] ? rnz[i] : 1'b1);
      m  = MW'(qq[QW:1]);
      sat[i] = 1'b0;
      if (zneg[i]) begin
        if (m > MW'(RES_NEG_MAG)) begin
          sat[i] = 1'b1;
          val[i] = RES_NEG_MAG;
        end else begin
          val[i] = -m[RES_W-1:0];
        end
      end else begin
        if (m > MW'(RES_POS_MAX)) begin
          sat[i] = 1'b1;
          val[i] = RES_POS_MAX;
        end else begin
          val[i] = m[RES_W-1:0];
        end
      end
    end
    res_nxt.rc     = d1_sb.rc;
    res_nxt.first  = val[0];
    res_nxt.second = val[0];
    res_nxt.imag   = '0;
    res_nxt.sat    = sat[0];
    case (d1_sb.rc)
      RC_TWO_REAL: begin
        res_nxt.second = val[1];
        res_nxt.sat    = sat[0] | sat[1];
      end
      RC_COMPLEX: begin
        res_nxt.imag = val[1];
        res_nxt.sat  = sat[0] | sat[1];
      end
      RC_A_ZERO: begin
        res_nxt.first  = '0;
        res_nxt.second = '0;
        res_nxt.sat    = 1'b0;
      end
      default: begin
        res_nxt.sat = sat[0];
      end
    endcase
  end

  // ---- output register and skid entry
  logic    out_v_r;
  result_t out_r;
  result_t skid_r;
  logic    arrive;

  assign arrive = dv_v && dv2_v && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_ready) begin
        skid_v_r <= 1'b0;
      end
    end else if (arrive) begin
      if (!out_v_r || out_ready) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (arrive) begin
      if (!out_v_r || out_ready) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_valid       = out_v_r;
  assign out_root_case   = out_r.rc;
  assign out_first_real  = out_r.first;
  assign out_second_real = out_r.second;
  assign out_imag_part   = out_r.imag;
  assign out_saturated   = out_r.sat;

endmodule

[bench/quadratic_root_solver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_test
// Self-checking bench for the quadratic root solver. Coefficient triples are
// sent with random gaps while the result side stalls at random. Each accepted
// beat is solved in the bench with wide exact integer math: exact discriminant,
// exact square root and one rounding. The solved roots are queued, and every
// output beat is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module quadratic_root_solver_test;
  import qrs_pkg::*;

  localparam int OFB        = 32;
  localparam int STALL_LIM  = 5000;
  localparam int LONG_HOLD  = 600;
  localparam int DRAIN_WAIT = 300;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_coef_a;
  logic signed [31:0] in_coef_b;
  logic signed [31:0] in_coef_c;
  logic               out_valid;
  logic               out_ready;
  root_case_t         out_root_case;
  logic signed [63:0] out_first_real;
  logic signed [63:0] out_second_real;
  logic signed [63:0] out_imag_part;
  logic               out_saturated;

  result_t pending_roots[$];
  int      errors;
  bit      gaps_on;
  bit      hold_req;
  int      idle_cycles;

  quadratic_root_solver #(.OUT_FRAC_BITS(OFB)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_root_case(out_root_case), .out_first_real(out_first_real),
    .out_second_real(out_second_real), .out_imag_part(out_imag_part),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // floor square root of a wide unsigned value
  function automatic logic [191:0] isqrt(input logic [191:0] x, output logic exact);
    logic [191:0] res;
    logic [191:0] bitv;
    res  = '0;
    bitv = 192'd1 << 190;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    exact = (x == 0);
    return res;
  endfunction

  // round((p + e*sqrt(x)) * 2^OFB / d), saturated to 64 bits
  function automatic logic [63:0] root_value(input logic signed [63:0] p, input int e,
                                             input logic [191:0] x, input logic [63:0] d,
                                             inout logic sat);
    logic [191:0] r, pm, z, q, rem;
    logic         exact, pneg, tneg, zneg;
    r = isqrt(x << (2 * OFB + 2), exact);
    if (e < 0 && !exact) r = r + 1;
    pneg = p < 0;
    pm   = {128'd0, (pneg ? -p : p)} << (OFB + 1);
    tneg = (e < 0) && (r != 0);
    if (pneg == tneg) begin
      z = pm + r; zneg = pneg;
    end else if (pm >= r) begin
      z = pm - r; zneg = pneg;
    end else begin
      z = r - pm; zneg = tneg;
    end
    if (z == 0) zneg = 1'b0;
    q   = z / {128'd0, d};
    rem = z % {128'd0, d};
    if (zneg) q = (q + (rem != 0)) >> 1;
    else      q = (q + 1) >> 1;
    if (q[191:64] != 0) begin
      sat = 1'b1;
      return zneg ? RES_NEG_MAG : RES_POS_MAX;
    end
    if (!zneg) begin
      if (q[63]) begin
        sat = 1'b1;
        return RES_POS_MAX;
      end
      return q[63:0];
    end
    if (q[63:0] > RES_NEG_MAG) begin
      sat = 1'b1;
      return RES_NEG_MAG;
    end
    return -q[63:0];
  endfunction

  function automatic result_t solve_roots(input logic signed [31:0] a,
                                          input logic signed [31:0] b,
                                          input logic signed [31:0] c);
    result_t                 res;
    logic signed [127:0]     disc;
    logic        [191:0]     dmag;
    logic signed [63:0]      p;
    logic        [63:0]      den;
    logic                    sat;
    int                      sa;
    res = '0;
    if (a == 0) begin
      res.rc = RC_A_ZERO;
      return res;
    end
    disc = 128'(b) * 128'(b) - 128'sd4 * 128'(a) * 128'(c);
    dmag = {64'd0, (disc < 0 ? -disc : disc)};
    den  = 64'(a < 0 ? -64'(a) : 64'(a)) << 1;
    sa   = a > 0 ? 1 : -1;
    p    = a > 0 ? -64'(b) : 64'(b);
    sat  = 1'b0;
    if (disc == 0) begin
      res.rc     = RC_DOUBLE;
      res.first  = root_value(p, 1, '0, den, sat);
      res.second = res.first;
    end else if (disc > 0) begin
      res.rc     = RC_TWO_REAL;
      res.first  = root_value(p, sa, dmag, den, sat);
      res.second = root_value(p, -sa, dmag, den, sat);
    end else begin
      res.rc     = RC_COMPLEX;
      res.first  = root_value(p, 1, '0, den, sat);
      res.second = res.first;
      res.imag   = root_value(64'sd0, sa, dmag, den, sat);
    end
    res.sat = sat;
    return res;
  endfunction

  // input beats: queue the solved roots
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      pending_roots.push_back(solve_roots(in_coef_a, in_coef_b, in_coef_c));
  end

  // output beats: compare against oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_roots.size() == 0) begin
        errors++;
        $display("%0t: unexpected output beat case=%0d", $time, out_root_case);
      end else begin
        want = pending_roots.pop_front();
        if (out_root_case !== want.rc) begin
          errors++;
          $display("%0t: root_case exp %0d got %0d", $time, want.rc, out_root_case);
        end
        if (out_first_real !== want.first) begin
          errors++;
          $display("%0t: first_real exp %h got %h", $time, want.first, out_first_real);
        end
        if (out_second_real !== want.second) begin
          errors++;
          $display("%0t: second_real exp %h got %h", $time, want.second, out_second_real);
        end
        if (out_imag_part !== want.imag) begin
          errors++;
          $display("%0t: imag_part exp %h got %h", $time, want.imag, out_imag_part);
        end
        if (out_saturated !== want.sat) begin
          errors++;
          $display("%0t: saturated exp %0d got %0d", $time, want.sat, out_saturated);
        end
      end
    end
  end

  // watchdog: cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIM) begin
      $display("quadratic_root_solver_test NOT OK");
      $finish;
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end else if (!gaps_on || $urandom_range(0, 2) == 0) begin
        n = 0;
      end else begin
        n = $urandom_range(0, 16);
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_coefs(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c);
    int gap;
    gap = (!gaps_on || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // random value, often small so roots stay in range
  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
      2:       return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom() >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    send_coefs(0, 0, 0);
    send_coefs(0, mx, mn);
    send_coefs(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);  // double root at -1
    send_coefs(32'h0001_0000, 0, 32'h0001_0000);              // +-i
    send_coefs(32'h0001_0000, 0, 32'hFFFF_0000);              // +-1
    send_coefs(32'hFFFF_0000, 0, 32'h0001_0000);              // negative a
    send_coefs(1, mx, 0);                                     // roots 0 and 1-2^31
    send_coefs(1, mn, 0);
    send_coefs(1, 0, mx);                                     // huge imaginary
    send_coefs(mx, mx, mx);
    send_coefs(mn, mn, mn);
    send_coefs(mn, mx, mn);
    send_coefs(mx, mn, mx);
    send_coefs(mn, 0, mx);
    send_coefs(mx, 0, mn);
    send_coefs(1, 1, 0);
    send_coefs(32'hFFFF_FFFF, 1, 1);
    send_coefs(3, 1, 0);                                      // rounding of 1/3
    send_coefs(32'h0000_0002, 32'hFFFF_FFFF, 0);              // roots 0 and 1/2
    send_coefs(32'h0000_0004, 32'h0000_0004, 32'h0000_0001);  // double at -1/2
    send_coefs(mn, 32'h0000_0001, 0);
  endtask

  // one random triple of a chosen flavor
  task automatic random_triple();
    logic signed [31:0] u, v;
    case ($urandom_range(0, 9))
      0:       send_coefs(0, rand_coef(), rand_coef());
      1, 2: begin
        // perfect square: (u*x + v)^2
        u = $signed($urandom_range(0, 92680)) - 46340;
        v = $signed($urandom_range(0, 92680)) - 46340;
        if ($urandom_range(0, 1)) send_coefs(u * u, 2 * u * v, v * v);
        else send_coefs(-(u * u), -(2 * u * v), -(v * v));
      end
      3: begin
        // factored (u*x - v)(x - 7)
        u = $signed($urandom_range(0, 2000)) - 1000;
        v = $signed($urandom_range(0, 2000)) - 1000;
        send_coefs(u, -(v + u * 7), v * 7);
      end
      4:       send_coefs($urandom(), $urandom(), $urandom());
      default: send_coefs(rand_coef(), rand_coef(), rand_coef());
    endcase
  endtask

  task automatic test_random(input int count);
    repeat (count) random_triple();
  endtask

  task automatic test_back_to_back(input int count);
    gaps_on = 1'b0;
    repeat (count) random_triple();
    gaps_on = 1'b1;
  endtask

  task automatic test_output_hold(input int count);
    hold_req = 1'b1;
    repeat (count) random_triple();
  endtask

  initial begin
    errors    = 0;
    gaps_on   = 1'b1;
    hold_req  = 1'b0;
    idle_cycles = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_coef_a = '0;
    in_coef_b = '0;
    in_coef_c = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(900);
    test_back_to_back(300);
    test_output_hold(250);
    test_random(300);

    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("quadratic_root_solver_test OK");
    end else begin
      $display("quadratic_root_solver_test NOT OK");
    end
    $finish;
  end

endmodule
